// ===== rtl/core/lsbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbd_pkg
// Shared types and constants of the weighted-sum and interval-bounds core.
// ----------------------------------------------------------------------------
package lsbd_pkg;

  localparam int MaxTerms = 256;
  localparam int TermAw   = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;

  localparam int ValW  = 64;
  localparam int IdxW  = 8;
  localparam int ProdW = 2 * ValW;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BOUND  = 2'd1,
    CMD_RECOMP = 2'd2,
    CMD_CHANGE = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_BOUNDS = 1'b0,
    KIND_TOTAL  = 1'b1
  } kind_e;

  // Control that travels beside the operands through the multiplier stages
  typedef struct packed {
    cmd_e cmd;
    logic last;
    logic eq;
    logic neg_a;
    logic neg_b;
  } side_t;

endpackage

// ===== rtl/core/lsbd_umul64.sv =====
// ----------------------------------------------------------------------------
// lsbd_umul64
// Three-stage unsigned 64x64 multiplier built from 32x32 partial products.
// ----------------------------------------------------------------------------
module lsbd_umul64 (
  input  logic                             clk_i,
  input  logic [2:0]                       en_i,   // stage enables, bit 0 first
  input  logic [lsbd_pkg::ValW-1:0]        a_i,
  input  logic [lsbd_pkg::ValW-1:0]        b_i,
  output logic [lsbd_pkg::ProdW-1:0]       prod_o
);

  localparam int HalfW = lsbd_pkg::ValW / 2;

  logic [lsbd_pkg::ValW-1:0]  ll_q, lh_q, hl_q, hh_q;
  logic [lsbd_pkg::ValW-1:0]  ll2_q, hh2_q;
  logic [lsbd_pkg::ValW:0]    mid_q;
  logic [lsbd_pkg::ProdW-1:0] prod_q;

  // Stage a: four partial products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ll_q <= a_i[HalfW-1:0]           * b_i[HalfW-1:0];
      lh_q <= a_i[HalfW-1:0]           * b_i[lsbd_pkg::ValW-1:HalfW];
      hl_q <= a_i[lsbd_pkg::ValW-1:HalfW] * b_i[HalfW-1:0];
      hh_q <= a_i[lsbd_pkg::ValW-1:HalfW] * b_i[lsbd_pkg::ValW-1:HalfW];
    end
  end

  // Stage b: fold the cross terms
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mid_q <= {1'b0, lh_q} + {1'b0, hl_q};
      ll2_q <= ll_q;
      hh2_q <= hh_q;
    end
  end

  // Stage c: full product
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      prod_q <= {hh2_q, ll2_q}
              + {{(lsbd_pkg::ProdW-lsbd_pkg::ValW-1-HalfW){1'b0}}, mid_q, {HalfW{1'b0}}};
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/linear_sum_bounds_delta_core.sv =====
// ----------------------------------------------------------------------------
// linear_sum_bounds_delta_core
// Coefficient table with saturating interval-bound accumulation, wrapping
// dot-product recompute and incremental total update on value changes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser command, tdata index/value_a/value_b, tlast
//  m_axis    out        tuser result_kind, tdata lower/upper/total
//  apb       in/out     output_offset at byte address 0 (64-bit data)
//
// While the output is not stalled, one beat per cycle enters and at most one
// result per cycle leaves. A beat passes the coefficient RAM read, the operand
// select, the magnitude stage, the split 64x64 multipliers (three stages), the
// saturate, min/max and accumulate stages into the output register.
// Reset clears all control state and the accumulators; the coefficient RAM
// holds no reset value and must be loaded before use.
// Each full stage holds while the next one is full and stalled, so bubbles are
// squeezed out and a waiting result does not block input while stages
// are empty.
// ----------------------------------------------------------------------------
module linear_sum_bounds_delta_core (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] term_index, [71:8] value_a, [135:72] value_b
  input  logic [135:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,

  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] lower_sum, [127:64] upper_sum, [191:128] total
  output logic [191:0] m_axis_tdata,
  // [0] result_kind
  output logic         m_axis_tuser,

  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int W = lsbd_pkg::ValW;

  // --------------------------------------------------------------------------
  // Input fields
  // --------------------------------------------------------------------------
  logic [lsbd_pkg::IdxW-1:0]   in_idx;
  logic [W-1:0]                in_va, in_vb;
  lsbd_pkg::cmd_e              in_cmd;
  logic [lsbd_pkg::TermAw-1:0] in_addr;
  logic                        in_ok;

  assign in_idx  = s_axis_tdata[7:0];
  assign in_va   = s_axis_tdata[71:8];
  assign in_vb   = s_axis_tdata[135:72];
  assign in_cmd  = lsbd_pkg::cmd_e'(s_axis_tuser);
  assign in_addr = lsbd_pkg::TermAw'(in_idx);
  assign in_ok   = 32'(in_idx) < lsbd_pkg::MaxTerms;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [W-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (psel && penable && pwrite && !paddr[3]) begin
      offset_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[3] ? '0 : offset_q;

  // --------------------------------------------------------------------------
  // Stage enables: a stage advances when empty or when its successor does
  // --------------------------------------------------------------------------
  logic [8:1] vld_q, vld_d;
  logic [8:1] en;
  logic       out_en;
  logic       m_vld_q;
  logic       accept;

  always_comb begin
    out_en = !m_vld_q || m_axis_tready;
    en[8]  = !vld_q[8] || out_en;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];
  assign accept        = s_axis_tvalid && en[1];

  // Loads finish in the RAM; only the other commands travel on
  always_comb begin
    vld_d = vld_q;
    if (en[1]) vld_d[1] = accept && (in_cmd != lsbd_pkg::CMD_LOAD);
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: coefficient RAM, written on a load beat, read on every beat
  // --------------------------------------------------------------------------
  logic [W-1:0] coef_mem [lsbd_pkg::MaxTerms];
  logic [W-1:0] rd1_q, va1_q, vb1_q;
  lsbd_pkg::cmd_e cmd1_q;
  logic         last1_q, ok1_q;

  always_ff @(posedge clk_i) begin
    if (accept && in_ok && (in_cmd == lsbd_pkg::CMD_LOAD)) begin
      coef_mem[in_addr] <= in_va;
    end
    if (en[1]) begin
      rd1_q   <= coef_mem[in_addr];
      va1_q   <= in_va;
      vb1_q   <= in_vb;
      cmd1_q  <= in_cmd;
      last1_q <= s_axis_tlast;
      ok1_q   <= in_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pick the multiplier operand (delta for a change event)
  // --------------------------------------------------------------------------
  logic [W-1:0]   c2_q, x2_q, vb2_q;
  lsbd_pkg::cmd_e cmd2_q;
  logic           last2_q, eq2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c2_q    <= ok1_q ? rd1_q : '0;
      x2_q    <= (cmd1_q == lsbd_pkg::CMD_CHANGE) ? (vb1_q - va1_q) : va1_q;
      vb2_q   <= vb1_q;
      eq2_q   <= (va1_q == vb1_q);
      cmd2_q  <= cmd1_q;
      last2_q <= last1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: magnitudes and product signs
  // --------------------------------------------------------------------------
  logic [W-1:0]    mc3_q, mx3_q, mvb3_q;
  lsbd_pkg::side_t side3_d;
  lsbd_pkg::side_t side_q [3:7];

  always_comb begin
    side3_d.cmd   = cmd2_q;
    side3_d.last  = last2_q;
    side3_d.eq    = eq2_q;
    side3_d.neg_a = c2_q[W-1] ^ x2_q[W-1];
    side3_d.neg_b = c2_q[W-1] ^ vb2_q[W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mc3_q  <= c2_q[W-1]  ? (-c2_q)  : c2_q;
      mx3_q  <= x2_q[W-1]  ? (-x2_q)  : x2_q;
      mvb3_q <= vb2_q[W-1] ? (-vb2_q) : vb2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4-6: two magnitude multipliers, side data follows
  // --------------------------------------------------------------------------
  logic [lsbd_pkg::ProdW-1:0] prod_a, prod_b;

  lsbd_umul64 u_mul_a (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .a_i    (mc3_q),
    .b_i    (mx3_q),
    .prod_o (prod_a)
  );

  lsbd_umul64 u_mul_b (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .a_i    (mc3_q),
    .b_i    (mvb3_q),
    .prod_o (prod_b)
  );

  // Side data rides along from stage 3 through stage 7
  always_ff @(posedge clk_i) begin
    if (en[3]) side_q[3] <= side3_d;
    for (int k = 4; k <= 7; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: saturate the signed products, keep the wrapped one
  // --------------------------------------------------------------------------
  logic [W-1:0] lim_a, lim_b, neg_pa, neg_pb;
  logic         sat_a, sat_b;
  logic [W-1:0] sa7_q, sb7_q, wa7_q;

  always_comb begin
    lim_a  = side_q[6].neg_a ? lsbd_pkg::ValMin : lsbd_pkg::ValMax;
    lim_b  = side_q[6].neg_b ? lsbd_pkg::ValMin : lsbd_pkg::ValMax;
    sat_a  = (|prod_a[lsbd_pkg::ProdW-1:W]) || (prod_a[W-1:0] > lim_a);
    sat_b  = (|prod_b[lsbd_pkg::ProdW-1:W]) || (prod_b[W-1:0] > lim_b);
    neg_pa = -prod_a[W-1:0];
    neg_pb = -prod_b[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      wa7_q     <= side_q[6].neg_a ? neg_pa : prod_a[W-1:0];
      if (sat_a) begin
        sa7_q <= side_q[6].neg_a ? lsbd_pkg::ValMin : lsbd_pkg::ValMax;
      end else begin
        sa7_q <= side_q[6].neg_a ? neg_pa : prod_a[W-1:0];
      end
      if (sat_b) begin
        sb7_q <= side_q[6].neg_b ? lsbd_pkg::ValMin : lsbd_pkg::ValMax;
      end else begin
        sb7_q <= side_q[6].neg_b ? neg_pb : prod_b[W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: order the two bound products
  // --------------------------------------------------------------------------
  logic [W-1:0]   lo8_q, hi8_q, wa8_q;
  lsbd_pkg::cmd_e cmd8_q;
  logic           last8_q, eq8_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      if ($signed(sa7_q) < $signed(sb7_q)) begin
        lo8_q <= sa7_q;
        hi8_q <= sb7_q;
      end else begin
        lo8_q <= sb7_q;
        hi8_q <= sa7_q;
      end
      wa8_q   <= wa7_q;
      cmd8_q  <= side_q[7].cmd;
      last8_q <= side_q[7].last;
      eq8_q   <= side_q[7].eq;
    end
  end

  // --------------------------------------------------------------------------
  // Final stage: accumulate and fill the output register
  // --------------------------------------------------------------------------
  logic [W-1:0] blo_q, blo_d, bhi_q, bhi_d, racc_q, racc_d, tot_q, tot_d;
  logic         bopen_q, bopen_d, ropen_q, ropen_d;
  logic [W-1:0] base_lo, base_hi, sum_lo, sum_hi, base_r;
  logic         ovf_lo, ovf_hi;

  logic         m_vld_d;
  logic         m_kind_q, m_kind_d;
  logic [W-1:0] m_lo_q, m_lo_d, m_hi_q, m_hi_d, m_tot_q, m_tot_d;

  always_comb begin
    // Open a pass from the offset, then saturating adds
    base_lo = bopen_q ? blo_q : offset_q;
    base_hi = bopen_q ? bhi_q : offset_q;
    sum_lo  = base_lo + lo8_q;
    sum_hi  = base_hi + hi8_q;
    ovf_lo  = (base_lo[W-1] == lo8_q[W-1]) && (sum_lo[W-1] != base_lo[W-1]);
    ovf_hi  = (base_hi[W-1] == hi8_q[W-1]) && (sum_hi[W-1] != base_hi[W-1]);
    base_r  = ropen_q ? racc_q : offset_q;

    blo_d    = blo_q;
    bhi_d    = bhi_q;
    bopen_d  = bopen_q;
    racc_d   = racc_q;
    ropen_d  = ropen_q;
    tot_d    = tot_q;
    m_vld_d  = m_vld_q;
    m_kind_d = m_kind_q;
    m_lo_d   = m_lo_q;
    m_hi_d   = m_hi_q;
    m_tot_d  = m_tot_q;

    if (out_en) begin
      m_vld_d = 1'b0;
      if (vld_q[8]) begin
        case (cmd8_q)
          lsbd_pkg::CMD_BOUND: begin
            blo_d   = ovf_lo ? (base_lo[W-1] ? lsbd_pkg::ValMin : lsbd_pkg::ValMax)
                             : sum_lo;
            bhi_d   = ovf_hi ? (base_hi[W-1] ? lsbd_pkg::ValMin : lsbd_pkg::ValMax)
                             : sum_hi;
            bopen_d = !last8_q;
            if (last8_q) begin
              m_vld_d  = 1'b1;
              m_kind_d = lsbd_pkg::KIND_BOUNDS;
              m_lo_d   = blo_d;
              m_hi_d   = bhi_d;
              m_tot_d  = '0;
            end
          end
          lsbd_pkg::CMD_RECOMP: begin
            racc_d  = base_r + wa8_q;
            ropen_d = !last8_q;
            if (last8_q) begin
              tot_d    = racc_d;
              m_vld_d  = 1'b1;
              m_kind_d = lsbd_pkg::KIND_TOTAL;
              m_lo_d   = '0;
              m_hi_d   = '0;
              m_tot_d  = racc_d;
            end
          end
          lsbd_pkg::CMD_CHANGE: begin
            // Drop a change whose new value equals its old value
            if (!eq8_q) begin
              tot_d    = tot_q + wa8_q;
              m_vld_d  = 1'b1;
              m_kind_d = lsbd_pkg::KIND_TOTAL;
              m_lo_d   = '0;
              m_hi_d   = '0;
              m_tot_d  = tot_d;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blo_q   <= '0;
      bhi_q   <= '0;
      bopen_q <= 1'b0;
      racc_q  <= '0;
      ropen_q <= 1'b0;
      tot_q   <= '0;
      m_vld_q <= 1'b0;
    end else begin
      blo_q   <= blo_d;
      bhi_q   <= bhi_d;
      bopen_q <= bopen_d;
      racc_q  <= racc_d;
      ropen_q <= ropen_d;
      tot_q   <= tot_d;
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_kind_q <= m_kind_d;
    m_lo_q   <= m_lo_d;
    m_hi_q   <= m_hi_d;
    m_tot_q  <= m_tot_d;
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {m_tot_q, m_hi_q, m_lo_q};

endmodule
